/* rtl/acmac_pkg.sv */
// acmac_pkg: shared types, constants and functions of the aes cmac tag engine
// the s-box table, the gf(2^8) column mix and the subkey doubling live here
// no dependencies
`timescale 1ns / 1ps

package acmac_pkg;

    typedef logic [127:0] blk_t;
    typedef logic [7:0]   byte_t;

    localparam byte_t RB_CONST  = 8'h87;
    localparam byte_t PAD_CONST = 8'h80;
    localparam int    NROUNDS   = 10;

    localparam byte_t SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    localparam byte_t RCON [NROUNDS] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    function automatic byte_t xtime(input byte_t a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic byte_t get_byte(input blk_t s, input int idx);
        return s[127 - 8 * idx -: 8];
    endfunction

    // sub bytes followed by shift rows
    function automatic blk_t sub_shift(input blk_t s);
        blk_t t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[127 - 8 * (c * 4 + i) -: 8] = SBOX[get_byte(s, ((c + i) % 4) * 4 + i)];
            end
        end
        return t;
    endfunction

    function automatic blk_t mix_columns(input blk_t s);
        blk_t  t;
        byte_t a0, a1, a2, a3;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            a0 = get_byte(s, c * 4);
            a1 = get_byte(s, c * 4 + 1);
            a2 = get_byte(s, c * 4 + 2);
            a3 = get_byte(s, c * 4 + 3);
            t[127 - 32 * c -: 8]  = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            t[119 - 32 * c -: 8]  = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            t[111 - 32 * c -: 8]  = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            t[103 - 32 * c -: 8]  = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
        return t;
    endfunction

    function automatic blk_t next_round_key(input blk_t k, input byte_t rc);
        logic [31:0] w0, w1, w2, w3, tw;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        tw = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        w0 = w0 ^ tw;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    // one-bit left shift with the conditional fold
    function automatic blk_t dbl(input blk_t v);
        return {v[126:0], 1'b0} ^ {120'd0, (v[127] ? RB_CONST : 8'h00)};
    endfunction

endpackage

/* rtl/acmac_aes_core.sv */
// acmac_aes_core: unrolled aes-128 encryption, combinational
// key schedule is expanded alongside the rounds; uses acmac_pkg
`timescale 1ns / 1ps

module acmac_aes_core (
    input  acmac_pkg::blk_t key,
    input  acmac_pkg::blk_t pt,
    output acmac_pkg::blk_t ct
);
    import acmac_pkg::*;

    blk_t rk [NROUNDS + 1];
    blk_t st [NROUNDS + 1];

    assign rk[0] = key;
    assign st[0] = pt ^ key;

    for (genvar r = 1; r <= NROUNDS; r++) begin : g_round
        assign rk[r] = next_round_key(rk[r - 1], RCON[r - 1]);
        if (r == NROUNDS) begin : g_last
            assign st[r] = sub_shift(st[r - 1]) ^ rk[r];
        end else begin : g_mid
            assign st[r] = mix_columns(sub_shift(st[r - 1])) ^ rk[r];
        end
    end

    assign ct = st[NROUNDS];

endmodule

/* rtl/aes_cmac_tag_engine.sv */
// aes_cmac_tag_engine: aes-128 cmac over 16-byte blocks, one block per clock while not stalled
// Takes one block per cycle when not stalled by subkey derivation or an untaken tag; the tag
// moves from the input register into the output register when the last block fires.
// The limit is the unrolled ten-round aes between the input register and the chain register.
// After a key write the subkey is derived with s_tready low. uses acmac_pkg and acmac_aes_core
`timescale 1ns / 1ps

module aes_cmac_tag_engine (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [135:0]  s_tdata,   // block_high[63:0], block_low[127:64], byte_count[132:128]
    input  logic          s_tlast,   // last_block
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [127:0]  m_tdata    // tag_high[63:0], tag_low[127:64]
);
    import acmac_pkg::*;

    logic [63:0] key_high_reg, key_low_reg;
    logic        ready_reg;
    blk_t        k1_reg;
    blk_t        chain_reg, chain_next;
    logic        s1_valid_reg;
    blk_t        s1_blk_reg;
    logic [4:0]  s1_cnt_reg;
    logic        s1_last_reg;
    logic        m_valid_reg;
    blk_t        m_data_reg;

    logic        cfg_wr, s1_fire, s_acc;
    blk_t        key, blk_pad, blk_x, aes_in, aes_out;
    logic [4:0]  n;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign prdata = paddr[3] ? key_low_reg : key_high_reg;
    assign key    = {key_high_reg, key_low_reg};

    assign s1_fire  = s1_valid_reg & ready_reg & (~s1_last_reg | ~m_valid_reg | m_tready);
    assign s_tready = ready_reg & (~s1_valid_reg | s1_fire);
    assign s_acc    = s_tvalid & s_tready;

    // padding of a partial last block and selection of the subkey for the last block
    always_comb begin
        n = (s1_cnt_reg > 5'd16) ? 5'd16 : s1_cnt_reg;
        blk_pad = s1_blk_reg;
        for (int i = 0; i < 16; i++) begin
            if (5'(i) == n) begin
                blk_pad[127 - 8 * i -: 8] = PAD_CONST;
            end else if (5'(i) > n) begin
                blk_pad[127 - 8 * i -: 8] = 8'h00;
            end
        end
        if (!s1_last_reg) begin
            blk_x = s1_blk_reg;
        end else if (n == 5'd16) begin
            blk_x = s1_blk_reg ^ k1_reg;
        end else begin
            blk_x = blk_pad ^ dbl(k1_reg);
        end
        aes_in = ready_reg ? (chain_reg ^ blk_x) : '0;
    end

    acmac_aes_core u_aes (
        .key (key),
        .pt  (aes_in),
        .ct  (aes_out)
    );

    assign chain_next = s1_last_reg ? '0 : aes_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            ready_reg    <= 1'b0;
            chain_reg    <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr) begin
                if (paddr[3]) begin
                    key_low_reg <= pwdata;
                end else begin
                    key_high_reg <= pwdata;
                end
                ready_reg <= 1'b0;
            end else if (!ready_reg) begin
                ready_reg <= 1'b1;
            end
            if (!ready_reg) begin
                k1_reg <= dbl(aes_out);
            end
            if (s_acc) begin
                s1_valid_reg <= 1'b1;
                s1_blk_reg   <= {s_tdata[63:0], s_tdata[127:64]};
                s1_cnt_reg   <= s_tdata[132:128];
                s1_last_reg  <= s_tlast;
            end else if (s1_fire) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire) begin
                chain_reg <= chain_next;
            end
            if (s1_fire && s1_last_reg) begin
                m_valid_reg <= 1'b1;
                m_data_reg  <= aes_out;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_data_reg[63:0], m_data_reg[127:64]};

endmodule

/* verif/tb_aes_cmac_tag_engine.sv */
// tb_aes_cmac_tag_engine: random and directed test of the aes-128 cmac tag engine
// a local aes and cmac predictor computes each expected tag, compared as tags leave the block
// depends on rtl/acmac_pkg.sv, rtl/acmac_aes_core.sv and rtl/aes_cmac_tag_engine.sv
`timescale 1ns / 1ps

module tb_aes_cmac_tag_engine;

    localparam int KEY_HIGH_ADDR = 0;
    localparam int KEY_LOW_ADDR  = 8;
    localparam int STALL_LIMIT   = 5000;

    typedef struct packed {
        logic [4:0]  count;
        logic        last;
        logic [63:0] lo;
        logic [63:0] hi;
    } req_t;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         psel = 0, penable = 0, pwrite = 0;
    logic [3:0]   paddr = 0;
    logic [63:0]  pwdata = 0;
    logic [63:0]  prdata;
    logic         pready;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [135:0] s_tdata = 0;
    logic         s_tlast = 0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [127:0] m_tdata;

    aes_cmac_tag_engine uut (.*);

    always #5 aclk = ~aclk;

    req_t           req_q[$];
    logic [127:0]   tag_q[$];
    int             errors = 0;
    int             idle_cnt = 0;
    bit             no_idle = 0;
    bit             cfg_busy = 0;

    logic [127:0] key_v = '0;
    logic [127:0] chain_v = '0;
    logic [127:0] k1_v = '0;
    bit           k1_ok = 0;

    bit sent_now = 0;
    int stall = 0;

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 0;
        for (int i = 0; i < 8; i++) begin
            if (b[0]) p ^= a;
            a = a[7] ? ((a << 1) ^ 8'h1b) : (a << 1);
            b = b >> 1;
        end
        return p;
    endfunction

    function automatic logic [7:0] sub_byte(input logic [7:0] x);
        logic [7:0] r, base;
        r = 1;
        base = x;
        for (int e = 254; e != 0; e = e >> 1) begin
            if (e & 1) r = gmul(r, base);
            base = gmul(base, base);
        end
        if (x == 0) r = 0;
        return r ^ {r[6:0], r[7]} ^ {r[5:0], r[7:6]} ^ {r[4:0], r[7:5]} ^ {r[3:0], r[7:4]}
            ^ 8'h63;
    endfunction

    function automatic logic [127:0] encrypt(input logic [127:0] key, input logic [127:0] pt);
        logic [7:0] rk[176];
        logic [7:0] s[16], t[16];
        logic [7:0] w0, w1, w2, w3, tmp, rc, a0, a1, a2, a3;
        logic [127:0] res;
        rc = 1;
        for (int i = 0; i < 16; i++) rk[i] = key[127 - 8 * i -: 8];
        for (int i = 16; i < 176; i += 4) begin
            w0 = rk[i - 4]; w1 = rk[i - 3]; w2 = rk[i - 2]; w3 = rk[i - 1];
            if ((i & 15) == 0) begin
                tmp = w0;
                w0 = sub_byte(w1) ^ rc;
                w1 = sub_byte(w2);
                w2 = sub_byte(w3);
                w3 = sub_byte(tmp);
                rc = gmul(rc, 8'h02);
            end
            rk[i] = rk[i - 16] ^ w0;
            rk[i + 1] = rk[i - 15] ^ w1;
            rk[i + 2] = rk[i - 14] ^ w2;
            rk[i + 3] = rk[i - 13] ^ w3;
        end
        for (int i = 0; i < 16; i++) s[i] = pt[127 - 8 * i -: 8] ^ rk[i];
        for (int r = 1; r <= 10; r++) begin
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++) t[c * 4 + i] = sub_byte(s[((c + i) & 3) * 4 + i]);
            if (r != 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = t[c * 4]; a1 = t[c * 4 + 1]; a2 = t[c * 4 + 2]; a3 = t[c * 4 + 3];
                    s[c * 4] = gmul(a0, 8'h02) ^ gmul(a1, 8'h03) ^ a2 ^ a3;
                    s[c * 4 + 1] = a0 ^ gmul(a1, 8'h02) ^ gmul(a2, 8'h03) ^ a3;
                    s[c * 4 + 2] = a0 ^ a1 ^ gmul(a2, 8'h02) ^ gmul(a3, 8'h03);
                    s[c * 4 + 3] = gmul(a0, 8'h03) ^ a1 ^ a2 ^ gmul(a3, 8'h02);
                end
            end else begin
                s = t;
            end
            for (int i = 0; i < 16; i++) s[i] ^= rk[r * 16 + i];
        end
        for (int i = 0; i < 16; i++) res[127 - 8 * i -: 8] = s[i];
        return res;
    endfunction

    function automatic logic [127:0] shift_fold(input logic [127:0] v);
        return {v[126:0], 1'b0} ^ (v[127] ? 128'h87 : 128'h0);
    endfunction

    // advance the running mac by one accepted block
    task automatic absorb_block(input req_t r);
        logic [127:0] blk;
        int n;
        blk = {r.hi, r.lo};
        n = int'(r.count);
        if (!k1_ok) begin
            k1_v = shift_fold(encrypt(key_v, '0));
            k1_ok = 1;
        end
        if (r.last) begin
            if (n > 16) n = 16;
            if (n == 16) begin
                blk ^= k1_v;
            end else begin
                for (int i = n; i < 16; i++) blk[127 - 8 * i -: 8] = 8'h00;
                blk[127 - 8 * n -: 8] = 8'h80;
                blk ^= shift_fold(k1_v);
            end
        end
        chain_v = encrypt(key_v, chain_v ^ blk);
        if (r.last) begin
            tag_q.push_back(chain_v);
            chain_v = '0;
        end
    endtask

    task automatic write_key(input int addr, input logic [63:0] val);
        @(negedge aclk);
        psel = 1; penable = 0; pwrite = 1; paddr = 4'(addr); pwdata = val;
        @(negedge aclk);
        penable = 1;
        @(posedge aclk);
        if (addr == KEY_HIGH_ADDR) key_v[127:64] = val;
        else key_v[63:0] = val;
        k1_ok = 0;
        @(negedge aclk);
        psel = 0; penable = 0; pwrite = 0;
    endtask

    task automatic push_block(input logic [63:0] hi, input logic [63:0] lo,
                              input int count, input bit last);
        req_t r;
        r.hi = hi; r.lo = lo; r.count = 5'(count); r.last = last;
        req_q.push_back(r);
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    task automatic push_message(input int nblk);
        int cnt;
        for (int i = 0; i < nblk - 1; i++) push_block(rnd64(), rnd64(), $urandom_range(0, 31), 0);
        cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 31) : $urandom_range(0, 16);
        push_block(rnd64(), rnd64(), cnt, 1);
    endtask

    task automatic drain();
        while (req_q.size() != 0 || s_tvalid || tag_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    // driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 0;
        end else begin
            if (!s_tvalid || sent_now) begin
                if (req_q.size() != 0 && (no_idle || $urandom_range(0, 99) >= 36)) begin
                    s_tvalid <= 1;
                    {s_tdata[132:128], s_tlast, s_tdata[127:64], s_tdata[63:0]} <= req_q.pop_front();
                end else begin
                    s_tvalid <= 0;
                end
            end
            m_tready <= no_idle || $urandom_range(0, 99) >= 36;
        end
    end

    // monitor
    always @(posedge aclk) begin
        logic [127:0] want;
        if (!aresetn) begin
            sent_now <= 0;
        end else begin
            sent_now <= s_tvalid && s_tready;
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall <= 0;
            else stall <= stall + 1;
            if (s_tvalid && s_tready) begin
                absorb_block({s_tdata[132:128], s_tlast, s_tdata[127:64], s_tdata[63:0]});
            end
            if (m_tvalid && m_tready) begin
                if (tag_q.size() == 0) begin
                    $display("%t unexpected tag, expected none, actual %h", $realtime, m_tdata);
                    errors++;
                end else begin
                    want = tag_q.pop_front();
                    if (m_tdata[63:0] !== want[127:64])
                        $display("%t tag_high expected %h actual %h", $realtime,
                                 want[127:64], m_tdata[63:0]);
                    if (m_tdata[127:64] !== want[63:0])
                        $display("%t tag_low expected %h actual %h", $realtime,
                                 want[63:0], m_tdata[127:64]);
                    if (m_tdata !== {want[63:0], want[127:64]}) errors++;
                end
            end
            if (stall >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        logic [63:0] key_set[4][2];
        int sent;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // rfc 4493 key, then directed messages
        write_key(KEY_HIGH_ADDR, 64'h2b7e151628aed2a6);
        write_key(KEY_LOW_ADDR, 64'habf7158809cf4f3c);
        push_block(64'h0, 64'h0, 0, 1);
        push_block(64'h6bc1bee22e409f96, 64'he93d7e117393172a, 16, 1);
        push_block(64'hffffffffffffffff, 64'hffffffffffffffff, 31, 0);
        push_block(64'hffffffffffffffff, 64'hffffffffffffffff, 0, 1);
        for (int n = 1; n < 16; n += 2) push_block(rnd64(), rnd64(), n, 1);
        push_block(64'hffffffffffffffff, 64'hffffffffffffffff, 17, 1);
        push_block(64'h0, 64'h0, 31, 1);
        push_block(rnd64(), rnd64(), 16, 0);
        push_block(rnd64(), rnd64(), 3, 1);
        drain();

        key_set[0] = '{64'h0, 64'h0};
        key_set[1] = '{64'hffffffffffffffff, 64'hffffffffffffffff};
        key_set[2] = '{rnd64(), rnd64()};
        key_set[3] = '{rnd64(), rnd64()};
        sent = 0;
        for (int ph = 0; ph < 6; ph++) begin
            write_key(KEY_HIGH_ADDR, key_set[ph % 4][0]);
            write_key(KEY_LOW_ADDR, key_set[ph % 4][1]);
            no_idle = (ph == 2);
            while (sent < (ph + 1) * 305) begin
                int nb;
                nb = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
                push_message(nb);
                sent += nb;
            end
            // a message left open across a key write keeps its chain
            if (ph == 4) push_block(rnd64(), rnd64(), 9, 0);
            drain();
        end
        no_idle = 0;
        push_message(2);
        drain();

        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
